/* rtl/core/s5rp_pkg.sv */
// s5rp_pkg: types and constants shared by the socks5 reply parser
// no dependencies; used by s5rp_step and socks5_reply_parser

package s5rp_pkg;

   // parse phase codes
   localparam logic [2:0] PH_VER   = 3'd0;
   localparam logic [2:0] PH_RC    = 3'd1;
   localparam logic [2:0] PH_RSV   = 3'd2;
   localparam logic [2:0] PH_ATYP  = 3'd3;
   localparam logic [2:0] PH_DLEN  = 3'd4;
   localparam logic [2:0] PH_ADDR  = 3'd5;
   localparam logic [2:0] PH_PORTH = 3'd6;
   localparam logic [2:0] PH_PORTL = 3'd7;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_VER   = 2'd1;
   localparam logic [1:0] ST_BAD_ATYP  = 2'd2;
   localparam logic [1:0] ST_REFUSED   = 2'd3;

   // protocol constants
   localparam logic [7:0] SOCKS_VERSION = 8'd5;
   localparam logic [7:0] ATYP_IPV4     = 8'd1;
   localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
   localparam logic [7:0] ATYP_IPV6     = 8'd4;
   localparam logic [7:0] LEN_IPV4      = 8'd4;
   localparam logic [7:0] LEN_IPV6      = 8'd16;

   localparam logic [2:0] ATYP_RESET    = 3'd1;

   typedef struct packed {
      logic [2:0] phase;
      logic [7:0] reply_code;
      logic [7:0] addr_type;
      logic [7:0] addr_len;
      logic [7:0] count;
      logic [7:0] port_high;
      logic       version_bad;
   } state_type;

   typedef struct packed {
      logic [7:0]  addr_byte;
      logic        addr_byte_valid;
      logic [7:0]  addr_index;
      logic        done_res;
      logic [1:0]  status;
      logic [7:0]  reply_code;
      logic [7:0]  reply_addr_type;
      logic [7:0]  addr_len;
      logic [15:0] port;
   } result_type;

endpackage

/* rtl/core/s5rp_req_if.sv */
// s5rp_req_if: input beat channel, one reply byte per beat
// depends on nothing

interface s5rp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       start_of_reply;

   modport source (output valid, output rx_byte, output start_of_reply, input ready);
   modport sink (input valid, input rx_byte, input start_of_reply, output ready);
endinterface

/* rtl/core/s5rp_rsp_if.sv */
// s5rp_rsp_if: result beat channel, one result per input byte
// depends on nothing

interface s5rp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  addr_byte;
   logic        addr_byte_valid;
   logic [7:0]  addr_index;
   logic        done_res;
   logic [1:0]  status;
   logic [7:0]  reply_code;
   logic [7:0]  reply_addr_type;
   logic [7:0]  addr_len;
   logic [15:0] port;

   modport source (output valid, output addr_byte, output addr_byte_valid,
                   output addr_index, output done_res, output status,
                   output reply_code, output reply_addr_type, output addr_len,
                   output port, input ready);
   modport sink (input valid, input addr_byte, input addr_byte_valid,
                 input addr_index, input done_res, input status,
                 input reply_code, input reply_addr_type, input addr_len,
                 input port, output ready);
endinterface

/* rtl/core/socks5_reply_parser.sv */
// socks5_reply_parser: top level of the socks5 reply byte parser
// depends on s5rp_pkg, s5rp_req_if, s5rp_rsp_if and s5rp_step
//
// req_bus carries the server reply one byte per beat; start_of_reply forces
// the byte to be read as the version byte. every accepted byte gives exactly
// one result beat on rsp_bus: address bytes with their index, and a done
// beat with status at the end of the reply (error at the address type byte,
// or ok with the port at the last port byte).
// csr_wr_en/csr_wr_data set the requested address type; write only while idle.
// the parse state and the result register both load at the accepting edge,
// and the result shows on rsp_bus the next cycle.
// throughput is one byte per cycle while rsp_bus is ready, set by the single result register.
// when the receiver stalls, the result register holds and req_bus.ready
// drops until the held beat is taken; a beat taken in the same cycle lets a
// new byte in at once. reset drops any held result beat, returns the parser
// to the version byte and sets the requested type to ipv4.

module socks5_reply_parser (
   input  logic             clock,
   input  logic             reset,
   s5rp_req_if.sink         req_bus,
   s5rp_rsp_if.source       rsp_bus,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_wr_data
);

   s5rp_pkg::state_type  state_ff, state_in;
   s5rp_pkg::result_type result_ff, result_in;
   logic [2:0]           exp_type_ff;
   logic                 rsp_valid_ff;
   logic                 accept;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   s5rp_step u_step (
      .cur            (state_ff),
      .expected_type  (exp_type_ff),
      .rx_byte        (req_bus.rx_byte),
      .start_of_reply (req_bus.start_of_reply),
      .nxt            (state_in),
      .res            (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= '{phase: s5rp_pkg::PH_VER, default: '0};
         exp_type_ff    <= s5rp_pkg::ATYP_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            exp_type_ff <= csr_wr_data;
         end
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.addr_byte       = result_ff.addr_byte;
   assign rsp_bus.addr_byte_valid = result_ff.addr_byte_valid;
   assign rsp_bus.addr_index      = result_ff.addr_index;
   assign rsp_bus.done_res        = result_ff.done_res;
   assign rsp_bus.status          = result_ff.status;
   assign rsp_bus.reply_code      = result_ff.reply_code;
   assign rsp_bus.reply_addr_type = result_ff.reply_addr_type;
   assign rsp_bus.addr_len        = result_ff.addr_len;
   assign rsp_bus.port            = result_ff.port;

   // a finished reply always returns to the version byte
   a_done_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && result_in.done_res |=> state_ff.phase == s5rp_pkg::PH_VER)
      else $error("parser did not restart after done");

   // address index stays inside the address
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.addr_byte_valid |->
         result_ff.addr_index < result_ff.addr_len)
      else $error("address index beyond address length");

   // an error status only comes with done
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.status != s5rp_pkg::ST_OK |-> result_ff.done_res)
      else $error("error status without done");

   // address and done never share a beat
   a_addr_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(result_ff.addr_byte_valid && result_ff.done_res))
      else $error("address byte and done in one beat");

endmodule

/* rtl/core/s5rp_step.sv */
// s5rp_step: next parse state and result for one reply byte
// depends on s5rp_pkg

module s5rp_step (
   input  s5rp_pkg::state_type  cur,
   input  logic [2:0]           expected_type,
   input  logic [7:0]           rx_byte,
   input  logic                 start_of_reply,
   output s5rp_pkg::state_type  nxt,
   output s5rp_pkg::result_type res
);

   logic [2:0] phase;
   logic [7:0] exp_byte;
   logic [7:0] count_inc;
   logic       type_ok;
   logic [1:0] st;

   assign phase     = start_of_reply ? s5rp_pkg::PH_VER : cur.phase;
   assign exp_byte  = {5'd0, expected_type};
   assign count_inc = cur.count + 8'd1;

   always_comb begin
      type_ok = (rx_byte == exp_byte) ||
                ((exp_byte == s5rp_pkg::ATYP_DOMAIN) &&
                 (rx_byte inside {s5rp_pkg::ATYP_IPV4, s5rp_pkg::ATYP_DOMAIN,
                                  s5rp_pkg::ATYP_IPV6}));
      if (cur.version_bad) begin
         st = s5rp_pkg::ST_BAD_VER;
      end else if (!type_ok) begin
         st = s5rp_pkg::ST_BAD_ATYP;
      end else if (cur.reply_code != 8'd0) begin
         st = s5rp_pkg::ST_REFUSED;
      end else begin
         st = s5rp_pkg::ST_OK;
      end
   end

   always_comb begin
      nxt = cur;
      res = '0;
      case (phase)
         s5rp_pkg::PH_VER: begin
            nxt.version_bad = (rx_byte != s5rp_pkg::SOCKS_VERSION);
            nxt.reply_code  = 8'd0;
            nxt.addr_type   = 8'd0;
            nxt.addr_len    = 8'd0;
            nxt.count       = 8'd0;
            nxt.port_high   = 8'd0;
            nxt.phase       = s5rp_pkg::PH_RC;
         end
         s5rp_pkg::PH_RC: begin
            nxt.reply_code = rx_byte;
            nxt.phase      = s5rp_pkg::PH_RSV;
         end
         s5rp_pkg::PH_RSV: begin
            nxt.phase = s5rp_pkg::PH_ATYP;
         end
         s5rp_pkg::PH_ATYP: begin
            nxt.addr_type = rx_byte;
            nxt.count     = 8'd0;
            res.status    = st;
            if (st != s5rp_pkg::ST_OK) begin
               res.done_res = 1'b1;
               nxt.phase    = s5rp_pkg::PH_VER;
            end else if (rx_byte == s5rp_pkg::ATYP_IPV4) begin
               nxt.addr_len = s5rp_pkg::LEN_IPV4;
               nxt.phase    = s5rp_pkg::PH_ADDR;
            end else if (rx_byte == s5rp_pkg::ATYP_DOMAIN) begin
               nxt.phase = s5rp_pkg::PH_DLEN;
            end else begin
               nxt.addr_len = s5rp_pkg::LEN_IPV6;
               nxt.phase    = s5rp_pkg::PH_ADDR;
            end
         end
         s5rp_pkg::PH_DLEN: begin
            nxt.addr_len = rx_byte;
            nxt.count    = 8'd0;
            nxt.phase    = (rx_byte == 8'd0) ? s5rp_pkg::PH_PORTH : s5rp_pkg::PH_ADDR;
         end
         s5rp_pkg::PH_ADDR: begin
            res.addr_byte       = rx_byte;
            res.addr_byte_valid = 1'b1;
            res.addr_index      = cur.count;
            nxt.count           = count_inc;
            if (count_inc >= cur.addr_len) begin
               nxt.phase = s5rp_pkg::PH_PORTH;
            end
         end
         s5rp_pkg::PH_PORTH: begin
            nxt.port_high = rx_byte;
            nxt.phase     = s5rp_pkg::PH_PORTL;
         end
         default: begin
            res.port     = {cur.port_high, rx_byte};
            res.done_res = 1'b1;
            nxt.phase    = s5rp_pkg::PH_VER;
         end
      endcase
      res.reply_code      = nxt.reply_code;
      res.reply_addr_type = nxt.addr_type;
      res.addr_len        = nxt.addr_len;
   end

endmodule
